>>> hdl/balt_pkg.sv
// Shared types and constants for the bond allow-list table.
// Used by the controller, the datapath and the top level; depends on nothing.
package balt_pkg;

  localparam int BALT_ENTRIES = 8;

  // A snapshot never emits more than this many addresses.
  localparam logic [3:0] SNAP_MAX = 4'd8;
  localparam logic [7:0] FAIL_MAX = 8'd255;

  typedef enum logic [3:0] {
    OP_LOOKUP   = 4'd0,
    OP_ADD      = 4'd1,
    OP_REMOVE   = 4'd2,
    OP_FAIL     = 4'd3,
    OP_LOGIN_OK = 4'd4,
    OP_ADMIT    = 4'd5,
    OP_OPEN     = 4'd6,
    OP_CLOSE    = 4'd7,
    OP_SNAPSHOT = 4'd8
  } balt_op_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  addr_type;
    logic [47:0] addr_value;
    logic [3:0]  snap_limit;
  } balt_in_t;

  typedef struct packed {
    logic        ok;
    logic        is_listed;
    logic [7:0]  fail_count;
    logic        window_now_open;
    logic [7:0]  out_type;
    logic [47:0] out_addr;
    logic        last;
  } balt_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic match;
    logic exec;
    logic snap_step;
  } balt_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_free;
    logic op_snap;
    logic snap_none;
    logic snap_last;
  } balt_sts_t;

endpackage

>>> hdl/balt_ctrl.sv
// Sequencing state machine for the bond allow-list table.
// Depends on balt_pkg for the command and status structs.
module balt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  balt_pkg::balt_sts_t sts,
  output balt_pkg::balt_cmd_t cmd
);
  import balt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EXEC,
    ST_SNAP
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = sts.out_free;
        if (sts.out_free) begin
          state_nxt = (sts.op_snap && !sts.snap_none) ? ST_SNAP : ST_IDLE;
        end
      end
      ST_SNAP: begin
        cmd.snap_step = sts.out_free;
        if (sts.out_free && sts.snap_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("controller issued more than one command");
  a_match_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.match)
    else $error("match did not follow capture");
  a_snap_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.snap_step && sts.snap_last) |=> (state_r == ST_IDLE && !in_stall))
    else $error("snapshot did not finish on its last entry");

endmodule

>>> hdl/balt_datapath.sv
// Peer table, match logic, write-back and output register of the allow-list table.
// Depends on balt_pkg; driven by balt_ctrl through the command struct.
module balt_datapath #(
  parameter int ENTRIES = balt_pkg::BALT_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  balt_pkg::balt_in_t  in_data,
  input  balt_pkg::balt_cmd_t cmd,
  output balt_pkg::balt_sts_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output balt_pkg::balt_out_t out_data
);
  import balt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  balt_in_t              in_r;
  logic [ENTRIES-1:0]    slot_used_r;
  logic [7:0]            slot_type_r   [ENTRIES];
  logic [47:0]           slot_addr_r   [ENTRIES];
  logic [ENTRIES-1:0]    slot_listed_r;
  logic [7:0]            slot_fail_r   [ENTRIES];
  logic                  win_r;

  logic [ENTRIES-1:0]    hit_r;
  logic [ENTRIES-1:0]    pending_r;
  logic [3:0]            remain_r;

  balt_out_t             out_r;
  logic                  out_valid_r;

  logic                  hit_any, free_any, claim, tgt_ok;
  logic [IDX_W-1:0]      hit_idx, free_idx, tgt_idx, snap_idx;
  logic [7:0]            cur_fail, fail_inc, fail_val;
  logic                  do_claim, do_clear, set_listed, set_fail, win_nxt;
  logic [ENTRIES-1:0]    pending_left;
  logic [3:0]            cap;
  logic                  out_free, out_load;
  balt_out_t             res;

  // Lowest-index encoders for the match, the free slots and the snapshot scan.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    snap_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_r[i])        hit_idx  = IDX_W'(i);
      if (!slot_used_r[i]) free_idx = IDX_W'(i);
      if (pending_r[i])    snap_idx = IDX_W'(i);
    end
  end

  assign hit_any  = |hit_r;
  assign free_any = ~&slot_used_r;
  assign claim    = !hit_any && free_any;
  assign tgt_ok   = hit_any || free_any;
  assign tgt_idx  = hit_any ? hit_idx : free_idx;
  assign cur_fail = claim ? 8'd0 : slot_fail_r[tgt_idx];
  assign fail_inc = (cur_fail == FAIL_MAX) ? cur_fail : cur_fail + 8'd1;
  assign cap      = (in_r.snap_limit > SNAP_MAX) ? SNAP_MAX : in_r.snap_limit;

  always_comb begin
    pending_left           = pending_r;
    pending_left[snap_idx] = 1'b0;
  end

  always_comb begin
    res                 = '0;
    res.window_now_open = win_r;
    res.last            = 1'b1;
    do_claim            = 1'b0;
    do_clear            = 1'b0;
    set_listed          = 1'b0;
    set_fail            = 1'b0;
    fail_val            = fail_inc;
    win_nxt             = win_r;
    if (cmd.snap_step) begin
      res.ok       = 1'b1;
      res.out_type = slot_type_r[snap_idx];
      res.out_addr = slot_addr_r[snap_idx];
      res.last     = sts.snap_last;
    end else begin
      unique case (in_r.op)
        OP_LOOKUP: begin
          res.ok        = hit_any;
          res.is_listed = hit_any && slot_listed_r[hit_idx];
        end
        OP_ADD: begin
          do_claim   = claim;
          set_listed = tgt_ok;
          res.ok     = tgt_ok;
        end
        OP_REMOVE: begin
          do_clear = hit_any;
          res.ok   = hit_any;
        end
        OP_FAIL: begin
          do_claim       = claim;
          set_fail       = tgt_ok;
          res.ok         = tgt_ok;
          res.fail_count = tgt_ok ? fail_inc : 8'd0;
        end
        OP_LOGIN_OK: begin
          set_fail = hit_any;
          fail_val = 8'd0;
          res.ok   = hit_any;
        end
        OP_ADMIT: begin
          if (win_r) begin
            do_claim            = claim;
            set_listed          = tgt_ok;
            win_nxt             = 1'b0;
            res.ok              = 1'b1;
            res.window_now_open = 1'b0;
          end
        end
        OP_OPEN: begin
          win_nxt             = 1'b1;
          res.ok              = 1'b1;
          res.window_now_open = 1'b1;
        end
        OP_CLOSE: begin
          win_nxt             = 1'b0;
          res.ok              = 1'b1;
          res.window_now_open = 1'b0;
        end
        // An empty snapshot gives a single result with ok low.
        OP_SNAPSHOT: res.ok = 1'b0;
        default:     res.ok = 1'b0;
      endcase
    end
  end

  assign sts.out_free  = out_free;
  assign sts.op_snap   = (in_r.op == OP_SNAPSHOT);
  assign sts.snap_none = (remain_r == 4'd0) || (pending_r == '0);
  assign sts.snap_last = (remain_r == 4'd1) || (pending_left == '0);

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = cmd.snap_step || (cmd.exec && !(sts.op_snap && !sts.snap_none));

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.match) begin
      for (int i = 0; i < ENTRIES; i++) begin
        hit_r[i] <= slot_used_r[i] && (slot_type_r[i] == in_r.addr_type) &&
                    (slot_addr_r[i] == in_r.addr_value);
      end
      pending_r <= slot_used_r & slot_listed_r;
      remain_r  <= cap;
    end
    if (cmd.snap_step) begin
      pending_r <= pending_left;
      remain_r  <= remain_r - 4'd1;
    end
  end

  // Only the in-use flags need clearing: nothing else of a free slot is ever read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
      win_r       <= 1'b0;
    end else if (cmd.exec) begin
      if (do_claim) slot_used_r[tgt_idx] <= 1'b1;
      if (do_clear) slot_used_r[hit_idx] <= 1'b0;
      win_r <= win_nxt;
    end
  end

  // A claimed slot starts unlisted with no failures unless the op itself sets them.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (do_claim) begin
        slot_type_r[tgt_idx] <= in_r.addr_type;
        slot_addr_r[tgt_idx] <= in_r.addr_value;
      end
      if (do_claim || set_listed) slot_listed_r[tgt_idx] <= set_listed;
      if (do_claim || set_fail)   slot_fail_r[tgt_idx]   <= set_fail ? fail_val : 8'd0;
      if (do_clear)               slot_listed_r[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $onehot0(hit_r))
    else $error("an address matched more than one slot");
  a_snap_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.snap_step |-> (pending_r != '0 && remain_r != 4'd0))
    else $error("snapshot step with nothing left to emit");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("a waiting result was overwritten");

endmodule

>>> hdl/bond_allow_list_table_unit.sv
// Bond allow-list table: ENTRIES peer slots (type, address, listed flag, failed-login
// count) and a pairing-window flag, driven by one op per input transaction. Items are
// handled one at a time: an item is captured while the unit is idle, all slots are
// compared into a registered hit vector in the match state, and the write-back and
// result load follow in the exec state once the output register is free. A snapshot
// then scans the listed slots in order, emitting one address per step. The next item
// is accepted as soon as the previous result sits in the output register; a stall on
// the result channel holds the exec and snapshot steps until that register is free.
// The table is empty straight after reset, with no clearing sweep.
module bond_allow_list_table_unit #(
  parameter int ENTRIES = balt_pkg::BALT_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  balt_pkg::balt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output balt_pkg::balt_out_t out_data
);
  import balt_pkg::*;

  balt_cmd_t cmd;
  balt_sts_t sts;

  balt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  balt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> dv/bond_allow_list_table_unit_tb.sv
// Self-checking testbench for the bond allow-list table unit.
// Needs balt_pkg and bond_allow_list_table_unit; a behavioural copy of the table
// predicts every result transaction, and the results are checked in order.
`timescale 1ns / 1ps

module bond_allow_list_table_unit_tb;
  import balt_pkg::*;

  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          DRAIN_CYCLES    = 20;
  localparam int          HOLD_CYCLES     = 150;
  localparam int          RANDOM_ITEMS    = 50;
  localparam int          QUIET_TAIL      = 20;
  localparam int          POOL_SIZE       = 12;
  localparam logic [3:0]  OP_UNUSED_FIRST = 4'd9;
  localparam logic [3:0]  OP_UNUSED_LAST  = 4'd15;
  localparam logic [47:0] ADDR_ALL_ONES   = 48'hFFFF_FFFF_FFFF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  balt_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  balt_out_t out_data;

  bond_allow_list_table_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Behavioural copy of the peer table.
  logic        peer_used   [BALT_ENTRIES];
  logic [7:0]  peer_type   [BALT_ENTRIES];
  logic [47:0] peer_addr   [BALT_ENTRIES];
  logic        peer_listed [BALT_ENTRIES];
  logic [7:0]  peer_fails  [BALT_ENTRIES];
  logic        pair_window;

  balt_out_t   awaited_results [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          idle_on;
  int          hold_start;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  logic [7:0]  pool_type [POOL_SIZE];
  logic [47:0] pool_addr [POOL_SIZE];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic int find_peer(logic [7:0] t, logic [47:0] a);
    for (int i = 0; i < BALT_ENTRIES; i++) begin
      if (peer_used[i] && peer_type[i] == t && peer_addr[i] == a) return i;
    end
    return -1;
  endfunction

  function automatic void clear_peer(int i);
    peer_used[i]   = 1'b0;
    peer_type[i]   = '0;
    peer_addr[i]   = '0;
    peer_listed[i] = 1'b0;
    peer_fails[i]  = '0;
  endfunction

  // An unknown address takes the lowest free slot as a fresh, unlisted entry.
  function automatic int claim_peer(logic [7:0] t, logic [47:0] a);
    int slot;
    slot = find_peer(t, a);
    if (slot >= 0) return slot;
    for (int i = 0; i < BALT_ENTRIES; i++) begin
      if (!peer_used[i]) begin
        clear_peer(i);
        peer_used[i] = 1'b1;
        peer_type[i] = t;
        peer_addr[i] = a;
        return i;
      end
    end
    return -1;
  endfunction

  task automatic apply_table_op(input balt_in_t it);
    int        slot;
    int        cap;
    int        n;
    balt_out_t res;
    balt_out_t snap_buf [BALT_ENTRIES];
    res = '0;
    n   = 0;
    case (it.op)
      OP_LOOKUP: begin
        slot = find_peer(it.addr_type, it.addr_value);
        if (slot >= 0) begin
          res.ok        = 1'b1;
          res.is_listed = peer_listed[slot];
        end
      end
      OP_ADD: begin
        slot = claim_peer(it.addr_type, it.addr_value);
        if (slot >= 0) begin
          peer_listed[slot] = 1'b1;
          res.ok            = 1'b1;
        end
      end
      OP_REMOVE: begin
        slot = find_peer(it.addr_type, it.addr_value);
        if (slot >= 0) begin
          clear_peer(slot);
          res.ok = 1'b1;
        end
      end
      OP_FAIL: begin
        slot = claim_peer(it.addr_type, it.addr_value);
        if (slot >= 0) begin
          if (peer_fails[slot] < FAIL_MAX) peer_fails[slot] = peer_fails[slot] + 8'd1;
          res.fail_count = peer_fails[slot];
          res.ok         = 1'b1;
        end
      end
      OP_LOGIN_OK: begin
        slot = find_peer(it.addr_type, it.addr_value);
        if (slot >= 0) begin
          peer_fails[slot] = '0;
          res.ok           = 1'b1;
        end
      end
      OP_ADMIT: begin
        // With the window open, admit succeeds even when no slot can be had.
        if (pair_window) begin
          slot = claim_peer(it.addr_type, it.addr_value);
          if (slot >= 0) peer_listed[slot] = 1'b1;
          pair_window = 1'b0;
          res.ok      = 1'b1;
        end
      end
      OP_OPEN: begin
        pair_window = 1'b1;
        res.ok      = 1'b1;
      end
      OP_CLOSE: begin
        pair_window = 1'b0;
        res.ok      = 1'b1;
      end
      OP_SNAPSHOT: begin
        cap = (it.snap_limit < SNAP_MAX) ? int'(it.snap_limit) : int'(SNAP_MAX);
        for (int i = 0; i < BALT_ENTRIES; i++) begin
          if (n < cap && peer_used[i] && peer_listed[i]) begin
            snap_buf[n]                 = '0;
            snap_buf[n].ok              = 1'b1;
            snap_buf[n].window_now_open = pair_window;
            snap_buf[n].out_type        = peer_type[i];
            snap_buf[n].out_addr        = peer_addr[i];
            n++;
          end
        end
      end
      default: ;
    endcase
    if (n > 0) begin
      snap_buf[n - 1].last = 1'b1;
      for (int k = 0; k < n; k++) awaited_results.push_back(snap_buf[k]);
    end else begin
      res.window_now_open = pair_window;
      res.last            = 1'b1;
      awaited_results.push_back(res);
    end
  endtask

  // ------------------------------------------------------------------ checking

  task automatic check_field(input string fname, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, fname, want, got);
    end
  endtask

  task automatic check_result(input balt_out_t got);
    balt_out_t want;
    if (awaited_results.size() == 0) begin
      mismatch_count++;
      $display("%0t ns: unexpected result, expected none, actual 0x%0h", $time, got);
    end else begin
      want = awaited_results.pop_front();
      check_field("ok", 48'(want.ok), 48'(got.ok));
      check_field("is_listed", 48'(want.is_listed), 48'(got.is_listed));
      check_field("fail_count", 48'(want.fail_count), 48'(got.fail_count));
      check_field("window_now_open", 48'(want.window_now_open),
                  48'(got.window_now_open));
      check_field("out_type", 48'(want.out_type), 48'(got.out_type));
      check_field("out_addr", want.out_addr, got.out_addr);
      check_field("last", 48'(want.last), 48'(got.last));
    end
  endtask

  // Results are checked before the input transaction of the same edge is predicted,
  // so the outcome never depends on process order.
  always @(posedge clk) begin
    if (!rst_n) begin
      pair_window = 1'b0;
      for (int i = 0; i < BALT_ENTRIES; i++) clear_peer(i);
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) apply_table_op(in_data);
    end
  end

  // Receiver: random stall bursts, plus a long hold-off whenever a test asks.
  always @(negedge clk) begin
    if (hold_start != hold_seen) begin
      hold_seen <= hold_start;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && rst_n && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ------------------------------------------------------------------ stimulus

  function automatic balt_in_t make_item(logic [3:0] op, logic [7:0] t, logic [47:0] a,
                                         logic [3:0] lim);
    balt_in_t it;
    it.op         = op;
    it.addr_type  = t;
    it.addr_value = a;
    it.snap_limit = lim;
    return it;
  endfunction

  // Starts at a falling edge and returns at the rising edge that accepts the item.
  task automatic send_item(input balt_in_t item);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 12);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_op(input logic [3:0] op, input logic [7:0] t, input logic [47:0] a);
    send_item(make_item(op, t, a, 4'($urandom_range(0, 15))));
  endtask

  task automatic send_snapshot(input logic [3:0] lim);
    send_item(make_item(OP_SNAPSHOT, 8'($urandom), 48'({$urandom, $urandom}), lim));
  endtask

  task automatic test_basic_ops;
    send_op(OP_LOOKUP, 8'h00, 48'h0);
    send_op(OP_ADD, 8'h00, 48'h0);
    send_op(OP_ADD, 8'hFF, ADDR_ALL_ONES);
    send_op(OP_LOOKUP, 8'hFF, ADDR_ALL_ONES);
    send_op(OP_LOOKUP, 8'hFE, ADDR_ALL_ONES);
    send_op(OP_FAIL, 8'h5A, 48'hA5A5_5A5A_A5A5);
    send_op(OP_LOOKUP, 8'h5A, 48'hA5A5_5A5A_A5A5);
    send_op(OP_LOGIN_OK, 8'h5A, 48'hA5A5_5A5A_A5A5);
    send_op(OP_LOGIN_OK, 8'h5A, 48'hA5A5_5A5A_A5A4);
    send_op(OP_REMOVE, 8'h00, 48'h0);
    send_op(OP_REMOVE, 8'h00, 48'h0);
  endtask

  task automatic test_window;
    send_op(OP_ADMIT, 8'h11, 48'h1111_2222_3333);
    send_op(OP_OPEN, 8'h00, 48'h0);
    send_op(OP_ADMIT, 8'h5A, 48'hA5A5_5A5A_A5A5);
    send_op(OP_ADMIT, 8'h11, 48'h1111_2222_3333);
    send_op(OP_OPEN, 8'h00, 48'h0);
    send_op(OP_ADMIT, 8'h11, 48'h1111_2222_3333);
    send_op(OP_OPEN, 8'h00, 48'h0);
    send_op(OP_CLOSE, 8'h00, 48'h0);
  endtask

  task automatic test_snapshot;
    send_snapshot(4'd0);
    send_snapshot(4'd1);
    send_snapshot(SNAP_MAX);
    send_snapshot(4'd15);
    send_op(OP_REMOVE, 8'hFF, ADDR_ALL_ONES);
    send_op(OP_REMOVE, 8'h5A, 48'hA5A5_5A5A_A5A5);
    send_op(OP_REMOVE, 8'h11, 48'h1111_2222_3333);
    send_snapshot(SNAP_MAX);
  endtask

  // The failure count must stick at its maximum and clear on a good login.
  task automatic test_fail_saturation;
    for (int k = 0; k < 256; k++) send_op(OP_FAIL, 8'h01, 48'h0000_0000_00FF);
    send_op(OP_LOGIN_OK, 8'h01, 48'h0000_0000_00FF);
    send_op(OP_FAIL, 8'h01, 48'h0000_0000_00FF);
    send_op(OP_REMOVE, 8'h01, 48'h0000_0000_00FF);
  endtask

  task automatic test_table_full;
    for (int k = 0; k < BALT_ENTRIES; k++)
      send_op(OP_ADD, 8'(k), {40'hF0F0_0000_00, 8'(k)});
    send_op(OP_ADD, 8'h77, 48'h7777_7777_7777);
    send_op(OP_FAIL, 8'h77, 48'h7777_7777_7777);
    send_op(OP_LOGIN_OK, 8'h77, 48'h7777_7777_7777);
    send_op(OP_OPEN, 8'h00, 48'h0);
    send_op(OP_ADMIT, 8'h77, 48'h7777_7777_7777);
    send_snapshot(SNAP_MAX);
    send_snapshot(4'd3);
    for (int k = 0; k < BALT_ENTRIES; k++)
      send_op(OP_REMOVE, 8'(k), {40'hF0F0_0000_00, 8'(k)});
  endtask

  task automatic test_unused_ops;
    send_op(OP_UNUSED_FIRST, 8'h00, 48'h0);
    send_op(OP_UNUSED_LAST, 8'hFF, ADDR_ALL_ONES);
  endtask

  // Hold the result channel off while the sender keeps offering transactions.
  task automatic test_backpressure;
    for (int k = 0; k < 4; k++) send_op(OP_ADD, 8'h20, 48'({$urandom, $urandom}));
    hold_start++;
    for (int k = 0; k < 16; k++) begin
      if (k % 2 == 0) send_snapshot(SNAP_MAX);
      else send_op(OP_LOOKUP, 8'h20, 48'({$urandom, $urandom}));
    end
  endtask

  function automatic balt_in_t random_pool_item();
    int         w;
    int         pick;
    logic [3:0] op;
    balt_in_t   it;
    w = $urandom_range(0, 99);
    if (w < 14) op = OP_LOOKUP;
    else if (w < 28) op = OP_ADD;
    else if (w < 40) op = OP_REMOVE;
    else if (w < 54) op = OP_FAIL;
    else if (w < 62) op = OP_LOGIN_OK;
    else if (w < 71) op = OP_ADMIT;
    else if (w < 80) op = OP_OPEN;
    else if (w < 84) op = OP_CLOSE;
    else if (w < 96) op = OP_SNAPSHOT;
    else op = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    it = make_item(op, 8'($urandom), 48'({$urandom, $urandom}),
                   4'($urandom_range(0, 15)));
    // Most transactions name a peer from a small pool so that entries get reused.
    if ($urandom_range(0, 9) != 0) begin
      pick          = $urandom_range(0, POOL_SIZE - 1);
      it.addr_type  = pool_type[pick];
      it.addr_value = pool_addr[pick];
    end
    return it;
  endfunction

  task automatic test_random;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_type[i] = 8'($urandom_range(0, 3));
      pool_addr[i] = 48'({$urandom, $urandom});
    end
    // Near misses: same address with another type, and an address one bit away.
    pool_addr[1] = pool_addr[0];
    pool_type[1] = pool_type[0] ^ 8'h80;
    pool_type[2] = pool_type[0];
    pool_addr[2] = pool_addr[0] ^ 48'h1;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      send_item(random_pool_item());
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    idle_on    = 1'b1;
    hold_start = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_ops();
    test_window();
    test_snapshot();
    test_fail_saturation();
    test_table_full();
    test_unused_ops();
    test_backpressure();
    test_random();

    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
